FILE: hdl/assert_macros.svh
// Assertion helper macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property under clock and active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert an implication under clock and active-low reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lmps_pkg.sv
package lmps_pkg;

  localparam int unsigned DefRows    = 5;
  localparam int unsigned DefColumns = 14;
  localparam int unsigned RowOutW    = 15;
  localparam int unsigned ColOutW    = 14;

  localparam logic [7:0]  PwmLimitRst = 8'd80;
  localparam logic [15:0] ColorMax    = 16'd255;

  // Layer codes
  localparam logic [1:0] LayerBase   = 2'd0;
  localparam logic [1:0] LayerMask   = 2'd1;
  localparam logic [1:0] LayerSticky = 2'd2;

  // Command codes
  localparam logic CmdTick  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  // Register indexes
  localparam logic [2:0] RegPwmLimit  = 3'd0;
  localparam logic [2:0] RegBacklight = 3'd1;
  localparam logic [2:0] RegCorr      = 3'd2;
  localparam logic [2:0] RegTemp      = 3'd3;
  localparam logic [2:0] RegAnimPer   = 3'd4;

  typedef struct packed {
    logic       command;
    logic [1:0] layer;
    logic [6:0] key_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic [14:0] row_lines;
    logic [13:0] column_lines;
    logic        animation_request;
  } out_item_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic tick;        // advance count, decide dim or load
    logic dim;         // run dimmer on current count
    logic load_start;  // start column load: drop column, advance
    logic load_row;    // load one key row from stores
    logic load_end;    // set column drive if any lit
    logic capture;     // capture result into output register
  } lmps_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic advance;     // count was at or above limit
    logic last_row;    // row counter at final row
  } lmps_sts_t;

endpackage

FILE: hdl/lmps_datapath.sv
module lmps_datapath
  import lmps_pkg::*;
#(
  parameter int unsigned ROWS    = DefRows,
  parameter int unsigned COLUMNS = DefColumns
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    item_i,
  input  logic        wr_en_i,
  input  lmps_cmd_t   cmd_i,
  output lmps_sts_t   sts_o,
  input  logic [7:0]  pwm_limit_i,
  input  logic        backlight_off_i,
  input  logic [23:0] correction_i,
  input  logic [23:0] temperature_i,
  input  logic [15:0] anim_period_i,
  output out_item_t   res_o
);

  localparam int unsigned Keys  = ROWS * COLUMNS;
  localparam int unsigned Lines = ROWS * 3;
  localparam int unsigned KeyW  = (Keys > 1) ? $clog2(Keys) : 1;
  localparam int unsigned ColW  = $clog2(COLUMNS);
  localparam int unsigned RowW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned LitW  = $clog2(Lines + 1);

  // Layer stores: valid bits per entry, data in memory arrays
  logic [23:0] base_mem   [Keys];
  logic [24:0] mask_mem   [Keys];
  logic [24:0] sticky_mem [Keys];
  logic [Keys-1:0] base_vld_q, mask_vld_q, sticky_vld_q;

  logic [8:0]      pwm_q;
  logic [ColW-1:0] col_q;
  logic [5:0]      on_time_q [Lines];
  logic [LitW-1:0] lit_q;
  logic [Lines-1:0] row_drv_q;
  logic [COLUMNS-1:0] col_drv_q;
  logic [15:0]     scan_q;
  logic            req_q;
  logic [RowW-1:0] row_idx_q;
  logic [RowW-1:0] row_idx_q_d1;
  out_item_t       res_q;

  logic key_ok;
  assign key_ok = ({1'b0, item_i.key_index} < 8'(Keys));
  logic [KeyW-1:0] wkey;
  assign wkey = item_i.key_index[KeyW-1:0];

  // Store writes
  always_ff @(posedge clk_i) begin
    if (wr_en_i && key_ok) begin
      if (item_i.layer == LayerBase)
        base_mem[wkey] <= {item_i.red, item_i.green, item_i.blue};
      if (item_i.layer == LayerMask)
        mask_mem[wkey] <= {(item_i.alpha != 8'd0), item_i.red, item_i.green, item_i.blue};
      if (item_i.layer == LayerSticky)
        sticky_mem[wkey] <= {(item_i.alpha != 8'd0), item_i.red, item_i.green, item_i.blue};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_vld_q   <= '0;
      mask_vld_q   <= '0;
      sticky_vld_q <= '0;
    end else if (wr_en_i && key_ok) begin
      if (item_i.layer == LayerBase)   base_vld_q[wkey]   <= 1'b1;
      if (item_i.layer == LayerMask)   mask_vld_q[wkey]   <= 1'b1;
      if (item_i.layer == LayerSticky) sticky_vld_q[wkey] <= 1'b1;
    end
  end

  // Registered read of the three layers for the key being loaded
  logic [KeyW-1:0] rkey;
  logic [ColW-1:0] col_next;
  logic [24:0] rd_base_q, rd_mask_q, rd_sticky_q;
  logic        rd_valid_q;
  assign col_next = (32'(col_q) == COLUMNS - 1) ? '0 : col_q + 1'b1;
  assign rkey = KeyW'(32'(row_idx_q) * COLUMNS + 32'(col_q));

  always_ff @(posedge clk_i) begin
    rd_base_q   <= base_vld_q[rkey]   ? {1'b1, base_mem[rkey]} : 25'd0;
    rd_mask_q   <= mask_vld_q[rkey]   ? mask_mem[rkey]         : 25'd0;
    rd_sticky_q <= sticky_vld_q[rkey] ? sticky_mem[rkey]       : 25'd0;
  end

  // Colour pick for the row just read
  logic [23:0] cl;
  always_comb begin
    if (rd_sticky_q[24])                        cl = rd_sticky_q[23:0];
    else if (rd_mask_q[24] && !backlight_off_i) cl = rd_mask_q[23:0];
    else if (!backlight_off_i)                  cl = rd_base_q[23:0];
    else                                        cl = 24'd0;
  end

  // Scale factor from one correction byte and one temperature byte
  function automatic logic [7:0] adj_of(logic [7:0] cc, logic [7:0] ct);
    logic [17:0] prod;
    prod = (18'(cc) + 18'd1) * (18'(ct) + 18'd1);
    return 8'((26'(prod) * 26'd255) >> 16);
  endfunction

  // Hold the per-channel scale factors, refreshed from the registers
  logic [7:0] adj_q [3];
  logic [2:0] scale_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) adj_q[c] <= '0;
      scale_q <= '0;
    end else begin
      for (int c = 0; c < 3; c++) begin
        adj_q[c]   <= adj_of(correction_i[16-8*c +: 8], temperature_i[16-8*c +: 8]);
        scale_q[c] <= (correction_i[16-8*c +: 8] != 8'd0)
                      && (temperature_i[16-8*c +: 8] != 8'd0);
      end
    end
  end

  // Per-channel scaling: divide by 255 via reciprocal and fix-up
  logic [5:0] ch_time [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [7:0]  colr;
      logic [15:0] cp;
      logic [15:0] q;
      logic [16:0] rem;
      logic [7:0]  res;
      colr = cl[16-8*c +: 8];
      cp   = 16'(colr) * 16'(adj_q[c]);
      q    = 16'((32'(cp) * 32'd257) >> 16);
      rem  = 17'(cp) - 17'(q) * 17'(ColorMax);
      if (rem >= 17'(ColorMax)) q = q + 16'd1;
      res  = scale_q[c] ? q[7:0] : colr;
      ch_time[c] = res[7:2];
    end
  end

  logic [1:0] ch_lit;
  assign ch_lit = 2'((ch_time[0] != 6'd0)) + 2'((ch_time[1] != 6'd0))
                + 2'((ch_time[2] != 6'd0));

  // Dimmer: count matches among on-times
  logic [Lines-1:0] match;
  logic [LitW-1:0]  match_cnt;
  always_comb begin
    match_cnt = '0;
    for (int r = 0; r < Lines; r++) begin
      match[r] = (pwm_q == {3'd0, on_time_q[r]});
      match_cnt = match_cnt + LitW'(match[r]);
    end
  end

  assign sts_o.advance  = ({1'b0, pwm_q} >= {2'b0, pwm_limit_i});
  assign sts_o.last_row = (32'(row_idx_q) == ROWS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_q      <= '0;
      col_q      <= '0;
      lit_q      <= '0;
      row_drv_q  <= '0;
      col_drv_q  <= '0;
      scan_q     <= '0;
      req_q      <= 1'b0;
      row_idx_q  <= '0;
      rd_valid_q <= 1'b0;
      for (int r = 0; r < Lines; r++) on_time_q[r] <= '0;
    end else begin
      rd_valid_q <= cmd_i.load_row;
      // Count advance and scan counting
      if (cmd_i.tick) begin
        if (sts_o.advance) begin
          pwm_q <= '0;
          if (anim_period_i != 16'd0 && 32'(col_q) == COLUMNS - 1) begin
            if (scan_q + 16'd1 >= anim_period_i) begin
              scan_q <= '0;
              req_q  <= 1'b1;
            end else begin
              scan_q <= scan_q + 16'd1;
              req_q  <= 1'b0;
            end
          end else begin
            req_q <= 1'b0;
          end
        end else begin
          pwm_q <= pwm_q + 9'd1;
          req_q <= 1'b0;
        end
      end else if (wr_en_i) begin
        req_q <= 1'b0;
      end
      // Dimmer on the new count
      if (cmd_i.dim) begin
        row_drv_q <= row_drv_q & ~match;
        if (lit_q <= match_cnt) begin
          lit_q <= '0;
          col_drv_q[col_q] <= 1'b0;
        end else begin
          lit_q <= lit_q - match_cnt;
        end
      end
      // Column load: drop old column and advance
      if (cmd_i.load_start) begin
        col_drv_q[col_q] <= 1'b0;
        col_q     <= col_next;
        lit_q     <= '0;
        row_idx_q <= '0;
      end
      if (cmd_i.load_row && !sts_o.last_row) row_idx_q <= row_idx_q + 1'b1;
      // Fold in one row of on-times
      if (rd_valid_q) begin
        for (int c = 0; c < 3; c++) begin
          on_time_q[3*row_idx_q_d1 + c] <= ch_time[c];
          if (ch_time[c] != 6'd0) row_drv_q[3*row_idx_q_d1 + c] <= 1'b1;
        end
        lit_q <= lit_q + LitW'(ch_lit);
      end
      if (cmd_i.load_end && lit_q != '0) col_drv_q[col_q] <= 1'b1;
    end
  end

  // Row index aligned with the registered read
  always_ff @(posedge clk_i) row_idx_q_d1 <= row_idx_q;

  // Result register
  logic [31:0] row_ext, col_ext;
  assign row_ext = 32'(row_drv_q);
  assign col_ext = 32'(col_drv_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_q.row_lines         <= row_ext[RowOutW-1:0];
      res_q.column_lines      <= col_ext[ColOutW-1:0];
      res_q.animation_request <= req_q;
    end
  end
  assign res_o = res_q;

endmodule

FILE: hdl/lmps_ctrl.sv
module lmps_ctrl
  import lmps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      command_i,
  output logic      wr_en_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  lmps_sts_t sts_i,
  output lmps_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StDecide, StLoadRow, StLoadTail, StLoadEnd, StCapture
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   acc;
  logic   adv_q;

  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign acc         = in_valid_i && in_ready_o;
  assign wr_en_o     = acc && (command_i == CmdWrite);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.tick       = acc && (command_i == CmdTick);
    unique case (state_q)
      StDecide: begin
        if (adv_q) cmd_o.load_start = 1'b1;
        else       cmd_o.dim        = 1'b1;
      end
      StLoadRow: cmd_o.load_row = 1'b1;
      StLoadEnd: cmd_o.load_end = 1'b1;
      StCapture: cmd_o.capture  = 1'b1;
      default: ;
    endcase
  end

  // Sequence: tick -> decide -> (rows) -> capture; write -> capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      adv_q       <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (acc) begin
            state_q <= (command_i == CmdTick) ? StDecide : StCapture;
            adv_q   <= sts_i.advance;
          end
        end
        StDecide:   state_q <= adv_q ? StLoadRow : StCapture;
        StLoadRow:  if (sts_i.last_row) state_q <= StLoadTail;
        StLoadTail: state_q <= StLoadEnd;
        StLoadEnd:  state_q <= StCapture;
        StCapture: begin
          state_q     <= StIdle;
          out_valid_q <= 1'b1;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

FILE: hdl/led_matrix_pwm_scanner.sv
// LED matrix PWM scanner.
// Input channel (in_valid_i/in_ready_o, in_item_i): each transfer is a colour
// write into the base, mask or sticky layer, or a PWM tick.
// Output channel (out_valid_o/out_ready_i, out_item_o): one result per input,
// holding the row drive, column drive and the animation-request pulse.
// A write passes the capture state, a dimming tick the decide and capture
// states; a tick that moves to the next column also passes the load-row,
// load-tail and load-end states, reading one key row per cycle from the
// three layer memories. One item is in flight at a time; the next is taken
// once the result is transferred, so a stalled receiver holds the block.
// Registers on the APB port: pwm_limit, backlight_off, correction_rgb,
// temperature_rgb, animation_period at byte offsets 0,4,8,12,16.
// Reset clears all drives, counters and layer valid bits and loads
// pwm_limit with 80.
module led_matrix_pwm_scanner
  import lmps_pkg::*;
#(
  parameter int unsigned ROWS    = DefRows,
  parameter int unsigned COLUMNS = DefColumns
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  pwm_limit_q;
  logic        backlight_q;
  logic [23:0] corr_q, temp_q;
  logic [15:0] anim_q;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_limit_q <= PwmLimitRst;
      backlight_q <= 1'b0;
      corr_q      <= '0;
      temp_q      <= '0;
      anim_q      <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegPwmLimit:  pwm_limit_q <= pwdata[7:0];
        RegBacklight: backlight_q <= pwdata[0];
        RegCorr:      corr_q      <= pwdata[23:0];
        RegTemp:      temp_q      <= pwdata[23:0];
        RegAnimPer:   anim_q      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      RegPwmLimit:  prdata = {24'd0, pwm_limit_q};
      RegBacklight: prdata = {31'd0, backlight_q};
      RegCorr:      prdata = {8'd0, corr_q};
      RegTemp:      prdata = {8'd0, temp_q};
      RegAnimPer:   prdata = {16'd0, anim_q};
      default:      prdata = '0;
    endcase
  end

  lmps_cmd_t cmd;
  lmps_sts_t sts;
  logic      wr_en;

  lmps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (in_item_i.command),
    .wr_en_o     (wr_en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lmps_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (in_item_i),
    .wr_en_i         (wr_en),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .pwm_limit_i     (pwm_limit_q),
    .backlight_off_i (backlight_q),
    .correction_i    (corr_q),
    .temperature_i   (temp_q),
    .anim_period_i   (anim_q),
    .res_o           (out_item_o)
  );

endmodule

FILE: hdl/lmps_checker.sv
`include "assert_macros.svh"

module lmps_checker
  import lmps_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, ##1 out_valid_o, "result dropped while stalled")
  `ASSERT_IMPL(a_no_take_busy, clk_i, rst_ni, out_valid_o, !in_ready_o, "input taken with result pending")
  `ASSERT_IMPL(a_col_onehot, clk_i, rst_ni, out_valid_o, $onehot0(out_item_o.column_lines), "more than one column lit")
  `ASSERT_IMPL(a_one_result, clk_i, rst_ni, out_valid_o && out_ready_i, ##1 !out_valid_o, "result repeated")

endmodule

bind led_matrix_pwm_scanner lmps_checker u_lmps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
